// ===== rtl/core/mwpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// mwpsc_pkg
// Shared widths, register map and types of the mecanum wheel speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mwpsc_pkg;

  localparam int NUM_WHEELS = 4;
  localparam int WHEEL_W    = 2;

  localparam int CMD_W  = 8;
  localparam int MOT_W  = 9;
  localparam int TGT_W  = 10;
  localparam int ERR_W  = 17;
  localparam int ACC_W  = 14;
  localparam int RES_W  = 14;
  localparam int GAIN_W = 12;
  localparam int LIM_W  = 13;
  localparam int WD_W   = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CMD_W-1:0] CMD_CENTRE = 8'd100;

  localparam logic [GAIN_W-1:0] KP_RST      = 12'd160;
  localparam logic [GAIN_W-1:0] KI_RST      = 12'd160;
  localparam logic [LIM_W-1:0]  INT_LIM_RST = 13'd7200;
  localparam logic [LIM_W-1:0]  DRV_LIM_RST = 13'd7000;
  localparam logic [LIM_W-1:0]  PERIOD_RST  = 13'd7200;
  localparam logic [WD_W-1:0]   WD_RST      = 8'd25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP       = 3'd0,
    REG_KI       = 3'd1,
    REG_INT_LIM  = 3'd2,
    REG_DRV_LIM  = 3'd3,
    REG_PERIOD   = 3'd4,
    REG_WD_TICKS = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [LIM_W-1:0]  integrator_limit;
    logic [LIM_W-1:0]  drive_limit;
    logic [LIM_W-1:0]  pwm_period;
    logic [WD_W-1:0]   watchdog_ticks;
  } cfg_t;

  // body-frame motion request, centered and with blocked directions removed
  typedef struct packed {
    logic signed [MOT_W-1:0] mx;
    logic signed [MOT_W-1:0] my;
    logic signed [MOT_W-1:0] mz;
  } motion_t;

  typedef struct packed {
    logic signed [RES_W-1:0] drive;
    logic [RES_W-1:0]        cmp_hi;
    logic [RES_W-1:0]        cmp_lo;
  } wheel_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/mwpsc_ram.sv =====
// ----------------------------------------------------------------------------
// mwpsc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpsc_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 4,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/mwpsc_cmd.sv =====
// ----------------------------------------------------------------------------
// mwpsc_cmd
// Held command, frame watchdog and obstacle masking, updated once per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpsc_cmd (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         cmd_new_i,
  input  logic [mwpsc_pkg::CMD_W-1:0]  cmd_x_i,
  input  logic [mwpsc_pkg::CMD_W-1:0]  cmd_y_i,
  input  logic [mwpsc_pkg::CMD_W-1:0]  cmd_z_i,
  input  logic                         block_pos_x_i,
  input  logic                         block_neg_x_i,
  input  logic                         block_neg_y_i,
  input  logic [mwpsc_pkg::WD_W-1:0]   watchdog_ticks_i,
  output mwpsc_pkg::motion_t           motion_o
);

  import mwpsc_pkg::*;

  logic [CMD_W-1:0] hx_q, hy_q, hz_q;
  logic [CMD_W-1:0] hx_d, hy_d, hz_d;
  logic [WD_W-1:0]  tick_q, tick_d;
  logic             seen_q, seen_d;
  logic             seen_l;

  logic signed [MOT_W-1:0] mx_raw, my_raw, mz_raw;

  always_comb begin
    hx_d   = cmd_new_i ? cmd_x_i : hx_q;
    hy_d   = cmd_new_i ? cmd_y_i : hy_q;
    hz_d   = cmd_new_i ? cmd_z_i : hz_q;
    seen_l = cmd_new_i | seen_q;
    if (tick_q == watchdog_ticks_i) begin
      tick_d = '0;
      seen_d = 1'b0;
      // no frame in the whole window: fall back to standstill
      if (!seen_l) begin
        hx_d = CMD_CENTRE;
        hy_d = CMD_CENTRE;
        hz_d = CMD_CENTRE;
      end
    end else begin
      tick_d = tick_q + 1'b1;
      seen_d = seen_l;
    end
  end

  // lateral axis is mirrored
  assign mx_raw = MOT_W'(CMD_CENTRE) - MOT_W'(hx_d);
  assign my_raw = MOT_W'(hy_d) - MOT_W'(CMD_CENTRE);
  assign mz_raw = MOT_W'(hz_d) - MOT_W'(CMD_CENTRE);

  always_comb begin
    motion_o.mx = mx_raw;
    motion_o.my = my_raw;
    motion_o.mz = mz_raw;
    if (block_pos_x_i && !mx_raw[MOT_W-1] && (mx_raw != '0)) begin
      motion_o.mx = '0;
    end
    if (block_neg_x_i && mx_raw[MOT_W-1]) begin
      motion_o.mx = '0;
    end
    if (block_neg_y_i && my_raw[MOT_W-1]) begin
      motion_o.my = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hx_q   <= CMD_CENTRE;
      hy_q   <= CMD_CENTRE;
      hz_q   <= CMD_CENTRE;
      tick_q <= '0;
      seen_q <= 1'b0;
    end else if (accept_i) begin
      hx_q   <= hx_d;
      hy_q   <= hy_d;
      hz_q   <= hz_d;
      tick_q <= tick_d;
      seen_q <= seen_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mwpsc_kin.sv =====
// ----------------------------------------------------------------------------
// mwpsc_kin
// Mecanum inverse kinematics: motion request to four wheel speed targets.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpsc_kin (
  input  mwpsc_pkg::motion_t                   motion_i,
  output logic signed [mwpsc_pkg::TGT_W-1:0]   tgt_o [mwpsc_pkg::NUM_WHEELS]
);

  import mwpsc_pkg::*;

  localparam int V_W    = 27;
  localparam int FRAC_W = 16;
  localparam int KIN_W  = 16;
  localparam int ROT_W  = MOT_W + KIN_W;

  // 0.33902 in Q16
  localparam logic signed [KIN_W-1:0] KIN_Q16 = 16'sd22218;

  // Q16 value to integer, rounding toward zero
  function automatic logic signed [TGT_W-1:0] trunc_q16(input logic signed [V_W-1:0] v);
    logic signed [V_W-1:0] b;
    b = v[V_W-1] ? (v + V_W'((1 << FRAC_W) - 1)) : v;
    return TGT_W'(b >>> FRAC_W);
  endfunction

  logic signed [ROT_W-1:0] rot_n;
  logic signed [V_W-1:0]   rot;
  logic signed [V_W-1:0]   lin_m, lin_p;

  always_comb begin
    rot_n = motion_i.mz * KIN_Q16;
    rot   = V_W'(rot_n);
    lin_m = (V_W'(motion_i.my) - V_W'(motion_i.mx)) <<< FRAC_W;
    lin_p = (V_W'(motion_i.my) + V_W'(motion_i.mx)) <<< FRAC_W;
    // wheels a and d are mounted mirrored
    tgt_o[0] = -trunc_q16(lin_m + rot);
    tgt_o[1] =  trunc_q16(lin_p - rot);
    tgt_o[2] =  trunc_q16(lin_m - rot);
    tgt_o[3] = -trunc_q16(lin_p + rot);
  end

endmodule

`default_nettype wire

// ===== rtl/core/mwpsc_pi.sv =====
// ----------------------------------------------------------------------------
// mwpsc_pi
// Shared incremental PI pipeline; per-wheel error and integrator kept in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpsc_pi #(
  parameter int ENC_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mwpsc_pkg::cfg_t                     cfg_i,
  input  logic                                issue_i,
  input  logic [mwpsc_pkg::WHEEL_W-1:0]       wheel_i,
  input  logic signed [mwpsc_pkg::TGT_W-1:0]  tgt_i,
  input  logic signed [ENC_WIDTH-1:0]         enc_i,
  output logic                                res_valid_o,
  output logic [mwpsc_pkg::WHEEL_W-1:0]       res_wheel_o,
  output mwpsc_pkg::wheel_res_t               res_o
);

  import mwpsc_pkg::*;

  localparam int ENTRY_W = ERR_W + ACC_W;
  localparam int DIFF_W  = ((ENC_WIDTH > TGT_W) ? ENC_WIDTH : TGT_W) + 1;
  localparam int CLP_W   = (DIFF_W > ERR_W + 1) ? DIFF_W : ERR_W + 1;
  localparam int DERR_W  = ERR_W + 1;
  localparam int PKP_W   = GAIN_W + 1 + DERR_W;
  localparam int PKI_W   = GAIN_W + 1 + ERR_W;
  localparam int SUM_W   = 32;
  localparam int FRAC_W  = 4;
  localparam int QUO_W   = SUM_W - FRAC_W;
  localparam int CMP_W   = LIM_W + 2;

  localparam logic signed [CLP_W-1:0] ERR_MAX = CLP_W'(65535);

  // stage 1: state read returns
  logic                       s1_valid_q;
  logic [WHEEL_W-1:0]         s1_wheel_q;
  logic signed [TGT_W-1:0]    s1_tgt_q;
  logic signed [ENC_WIDTH-1:0] s1_enc_q;
  // stage 2: error terms
  logic                       s2_valid_q;
  logic [WHEEL_W-1:0]         s2_wheel_q;
  logic signed [ERR_W-1:0]    s2_err_q;
  logic signed [DERR_W-1:0]   s2_derr_q;
  logic signed [ACC_W-1:0]    s2_acc_q;
  // stage 3: products, integrator update and write-back
  logic                       s3_valid_q;
  logic [WHEEL_W-1:0]         s3_wheel_q;
  logic signed [ERR_W-1:0]    s3_err_q;
  logic signed [ACC_W-1:0]    s3_acc_q;
  logic signed [PKP_W-1:0]    s3_pkp_q;
  logic signed [PKI_W-1:0]    s3_pki_q;
  // stage 4: output clamp and bridge compares
  logic                       s4_valid_q;
  logic [WHEEL_W-1:0]         s4_wheel_q;
  logic signed [ACC_W-1:0]    s4_acc_q;

  logic [NUM_WHEELS-1:0]      vld_q;
  logic [ENTRY_W-1:0]         rdata;
  logic [ENTRY_W-1:0]         entry;
  logic signed [ERR_W-1:0]    prev_err;
  logic signed [ACC_W-1:0]    acc_old;
  logic signed [CLP_W-1:0]    dif;
  logic signed [ERR_W-1:0]    err;
  logic signed [DERR_W-1:0]   derr;
  logic signed [PKP_W-1:0]    pkp;
  logic signed [PKI_W-1:0]    pki;
  logic signed [SUM_W-1:0]    sum;
  logic signed [QUO_W-1:0]    quo;
  logic signed [QUO_W-1:0]    int_lim;
  logic signed [ACC_W-1:0]    acc_new;
  logic signed [ACC_W-1:0]    drv_lim;
  logic signed [ACC_W-1:0]    drv;
  logic signed [CMP_W-1:0]    per;
  logic signed [CMP_W-1:0]    hi_full, lo_full;

  // a wheel's read is issued, it passes stages 1 and 2 and is written back
  // from stage 3; with four wheels in rotation the next read of the same entry
  // comes no earlier than the cycle after that write, so no forwarding path is needed
  mwpsc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_WHEELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s3_valid_q),
    .waddr_i (s3_wheel_q),
    .wdata_i ({s3_err_q, acc_new}),
    .raddr_i (wheel_i),
    .rdata_o (rdata)
  );

  // entries never written read as zero
  always_comb begin
    entry    = vld_q[s1_wheel_q] ? rdata : '0;
    prev_err = entry[ENTRY_W-1 -: ERR_W];
    acc_old  = entry[ACC_W-1:0];
    dif      = CLP_W'(s1_tgt_q) - CLP_W'(s1_enc_q);
    if (dif > ERR_MAX) begin
      err = ERR_W'(ERR_MAX);
    end else if (dif < -ERR_MAX) begin
      err = ERR_W'(-ERR_MAX);
    end else begin
      err = ERR_W'(dif);
    end
    derr = DERR_W'(err) - DERR_W'(prev_err);
  end

  always_comb begin
    pkp = PKP_W'($signed({1'b0, cfg_i.kp_gain})) * PKP_W'(s2_derr_q);
    pki = PKI_W'($signed({1'b0, cfg_i.ki_gain})) * PKI_W'(s2_err_q);
  end

  always_comb begin
    sum = (SUM_W'(s3_acc_q) <<< FRAC_W) + SUM_W'(s3_pkp_q) + SUM_W'(s3_pki_q);
    quo = QUO_W'(sum >>> FRAC_W);
    // shift floors, step back up for negative sums with a remainder
    if (sum[SUM_W-1] && (sum[FRAC_W-1:0] != '0)) begin
      quo = quo + QUO_W'(1);
    end
    int_lim = QUO_W'($signed({1'b0, cfg_i.integrator_limit}));
    if (quo > int_lim) begin
      acc_new = ACC_W'(int_lim);
    end else if (quo < -int_lim) begin
      acc_new = ACC_W'(-int_lim);
    end else begin
      acc_new = ACC_W'(quo);
    end
  end

  always_comb begin
    drv_lim = ACC_W'($signed({1'b0, cfg_i.drive_limit}));
    if (s4_acc_q > drv_lim) begin
      drv = drv_lim;
    end else if (s4_acc_q < -drv_lim) begin
      drv = -drv_lim;
    end else begin
      drv = s4_acc_q;
    end
    per = CMP_W'($signed({1'b0, cfg_i.pwm_period}));
    if (!drv[ACC_W-1] && (drv != '0)) begin
      hi_full = per;
      lo_full = per - CMP_W'(drv);
    end else begin
      hi_full = per + CMP_W'(drv);
      lo_full = per;
    end
    res_o.drive  = drv;
    res_o.cmp_hi = hi_full[CMP_W-1] ? '0 : RES_W'(hi_full);
    res_o.cmp_lo = lo_full[CMP_W-1] ? '0 : RES_W'(lo_full);
  end

  assign res_valid_o = s4_valid_q;
  assign res_wheel_o = s4_wheel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      vld_q      <= '0;
    end else begin
      s1_valid_q <= issue_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      if (s3_valid_q) begin
        vld_q[s3_wheel_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_wheel_q <= wheel_i;
    s1_tgt_q   <= tgt_i;
    s1_enc_q   <= enc_i;
    s2_wheel_q <= s1_wheel_q;
    s2_err_q   <= err;
    s2_derr_q  <= derr;
    s2_acc_q   <= acc_old;
    s3_wheel_q <= s2_wheel_q;
    s3_err_q   <= s2_err_q;
    s3_acc_q   <= s2_acc_q;
    s3_pkp_q   <= pkp;
    s3_pki_q   <= pki;
    s4_wheel_q <= s3_wheel_q;
    s4_acc_q   <= acc_new;
  end

endmodule

`default_nettype wire

// ===== rtl/core/mecanum_wheel_pi_speed_controller.sv =====
// ----------------------------------------------------------------------------
// mecanum_wheel_pi_speed_controller
// Command hold with watchdog, mecanum kinematics and four incremental PI loops.
// ----------------------------------------------------------------------------
// One input transaction is one control tick and yields exactly one output
// transaction with the four clamped drives and their H-bridge compare pairs.
// The four wheels share a single PI pipeline whose per-wheel state (last
// error and integrator) sits in a small RAM, one wheel per cycle once a tick
// has started; a new tick is accepted as soon as the last wheel of the
// previous one has been issued. Up to three finished results are buffered,
// so the input keeps flowing while the output is stalled until all three
// result slots are reserved. The wheel-state RAM needs no clearing pass
// after reset. Configuration registers may only be written while no tick is
// in flight.
`default_nettype none

module mecanum_wheel_pi_speed_controller #(
  parameter int  ENC_WIDTH = 16,
  localparam int IN_BITS   = mwpsc_pkg::NUM_WHEELS * ENC_WIDTH + 3 * mwpsc_pkg::CMD_W + 3,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_W     = mwpsc_pkg::NUM_WHEELS * 3 * mwpsc_pkg::RES_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // enc_a, enc_b, enc_c, enc_d, cmd_x, cmd_y, cmd_z, block_pos_x,
  // block_neg_x, block_neg_y, zero padding
  input  logic [IN_W-1:0]                     s_axis_tdata,
  // cmd_new
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // drive_a, drive_b, drive_c, drive_d, cmp_hi_a, cmp_lo_a, cmp_hi_b,
  // cmp_lo_b, cmp_hi_c, cmp_lo_c, cmp_hi_d, cmp_lo_d
  output logic [OUT_W-1:0]                    m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [mwpsc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mwpsc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  import mwpsc_pkg::*;

  localparam int CMD_BASE  = NUM_WHEELS * ENC_WIDTH;
  localparam int FLAG_BASE = CMD_BASE + 3 * CMD_W;
  localparam int OUT_DEPTH = 3;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
  localparam logic [WHEEL_W-1:0] LAST_WHEEL = WHEEL_W'(NUM_WHEELS - 1);

  cfg_t cfg_q;

  logic                        accept;
  motion_t                     motion;
  logic                        item_valid_q;
  motion_t                     item_mot_q;
  logic signed [ENC_WIDTH-1:0] item_enc_q [NUM_WHEELS];
  logic [WHEEL_W-1:0]          wheel_q;
  logic signed [TGT_W-1:0]     tgt [NUM_WHEELS];

  logic                        issue;
  logic                        last_issue;
  logic                        start;
  logic [CNT_W-1:0]            rsv_q;

  logic                        res_valid;
  logic [WHEEL_W-1:0]          res_wheel;
  wheel_res_t                  res;
  wheel_res_t                  asm_q [NUM_WHEELS];
  wheel_res_t                  cur;
  logic                        push;
  logic                        pop;
  logic [OUT_W-1:0]            push_data;
  logic [OUT_W-1:0]            fifo_q [OUT_DEPTH];
  logic [PTR_W-1:0]            wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]            cnt_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain          <= KP_RST;
      cfg_q.ki_gain          <= KI_RST;
      cfg_q.integrator_limit <= INT_LIM_RST;
      cfg_q.drive_limit      <= DRV_LIM_RST;
      cfg_q.pwm_period       <= PERIOD_RST;
      cfg_q.watchdog_ticks   <= WD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KP:       cfg_q.kp_gain          <= cfg_wdata_i[GAIN_W-1:0];
        REG_KI:       cfg_q.ki_gain          <= cfg_wdata_i[GAIN_W-1:0];
        REG_INT_LIM:  cfg_q.integrator_limit <= cfg_wdata_i[LIM_W-1:0];
        REG_DRV_LIM:  cfg_q.drive_limit      <= cfg_wdata_i[LIM_W-1:0];
        REG_PERIOD:   cfg_q.pwm_period       <= cfg_wdata_i[LIM_W-1:0];
        REG_WD_TICKS: cfg_q.watchdog_ticks   <= cfg_wdata_i[WD_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  mwpsc_cmd u_cmd (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .cmd_new_i        (s_axis_tuser),
    .cmd_x_i          (s_axis_tdata[CMD_BASE +: CMD_W]),
    .cmd_y_i          (s_axis_tdata[CMD_BASE + CMD_W +: CMD_W]),
    .cmd_z_i          (s_axis_tdata[CMD_BASE + 2 * CMD_W +: CMD_W]),
    .block_pos_x_i    (s_axis_tdata[FLAG_BASE]),
    .block_neg_x_i    (s_axis_tdata[FLAG_BASE + 1]),
    .block_neg_y_i    (s_axis_tdata[FLAG_BASE + 2]),
    .watchdog_ticks_i (cfg_q.watchdog_ticks),
    .motion_o         (motion)
  );

  // wheel sequencer: a new tick enters only when a result slot is reserved for it
  assign start         = item_valid_q && (wheel_q == '0) && (rsv_q < CNT_W'(OUT_DEPTH));
  assign issue         = item_valid_q && ((wheel_q != '0) || start);
  assign last_issue    = issue && (wheel_q == LAST_WHEEL);
  assign s_axis_tready = !item_valid_q || last_issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      wheel_q      <= '0;
    end else begin
      if (accept) begin
        item_valid_q <= 1'b1;
      end else if (last_issue) begin
        item_valid_q <= 1'b0;
      end
      // wraps back to wheel a after the last wheel
      if (issue) begin
        wheel_q <= wheel_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_mot_q <= motion;
      for (int w = 0; w < NUM_WHEELS; w++) begin
        item_enc_q[w] <= s_axis_tdata[w * ENC_WIDTH +: ENC_WIDTH];
      end
    end
  end

  mwpsc_kin u_kin (
    .motion_i (item_mot_q),
    .tgt_o    (tgt)
  );

  mwpsc_pi #(
    .ENC_WIDTH (ENC_WIDTH)
  ) u_pi (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .issue_i     (issue),
    .wheel_i     (wheel_q),
    .tgt_i       (tgt[wheel_q]),
    .enc_i       (item_enc_q[wheel_q]),
    .res_valid_o (res_valid),
    .res_wheel_o (res_wheel),
    .res_o       (res)
  );

  // collect the four wheel results of a tick
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      asm_q[res_wheel] <= res;
    end
  end

  assign push = res_valid && (res_wheel == LAST_WHEEL);
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cur       = res;
    push_data = '0;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      cur = (w == NUM_WHEELS - 1) ? res : asm_q[w];
      push_data[w * RES_W +: RES_W]                    = cur.drive;
      push_data[(NUM_WHEELS + 2 * w) * RES_W +: RES_W] = cur.cmp_hi;
      push_data[(NUM_WHEELS + 2 * w + 1) * RES_W +: RES_W] = cur.cmp_lo;
    end
  end

  // result buffer; reservations keep it from ever overflowing
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      rsv_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
      rsv_q <= rsv_q + CNT_W'(start) - CNT_W'(pop);
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/core/mwpsc_chk.sv =====
// ----------------------------------------------------------------------------
// mwpsc_chk
// Port-level checks of the speed controller result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpsc_chk (
  input logic                                                     clk_i,
  input logic                                                     rst_ni,
  input logic [mwpsc_pkg::NUM_WHEELS*3*mwpsc_pkg::RES_W-1:0]      m_axis_tdata,
  input logic                                                     m_axis_tvalid,
  input logic                                                     m_axis_tready
);

  import mwpsc_pkg::*;

  localparam int HI_A = NUM_WHEELS * RES_W;
  localparam int LO_A = HI_A + RES_W;

  logic [RES_W-1:0] drive_a, cmp_hi_a, cmp_lo_a;

  assign drive_a  = m_axis_tdata[0 +: RES_W];
  assign cmp_hi_a = m_axis_tdata[HI_A +: RES_W];
  assign cmp_lo_a = m_axis_tdata[LO_A +: RES_W];

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // drives are clamped symmetrically, so the most negative code never shows
  a_drive_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (drive_a != {1'b1, {(RES_W-1){1'b0}}}))
    else $error("drive outside symmetric range");

  // forward drive lowers the low-side compare, reverse drive the high side
  a_cmp_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !drive_a[RES_W-1] && (drive_a != '0) |-> (cmp_lo_a <= cmp_hi_a))
    else $error("compare pair inconsistent with forward drive");

  a_cmp_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (drive_a[RES_W-1] || (drive_a == '0)) |-> (cmp_hi_a <= cmp_lo_a))
    else $error("compare pair inconsistent with reverse drive");

endmodule

bind mecanum_wheel_pi_speed_controller mwpsc_chk u_mwpsc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire
